/* rtl/tpig_pkg.sv */
// Shared types and constants for the terrain patch index generator.
// No dependencies; imported by every module of the block.
`default_nettype none
package tpig_pkg;

   localparam int unsigned SizeW  = 7;
   localparam int unsigned EdgeW  = 4;
   localparam int unsigned CoordW = 6;
   localparam int unsigned IndexW = 13;
   localparam int unsigned CsrIdxW = 1;

   // register indexes on the csr port
   localparam logic [CsrIdxW-1:0] CsrQuads = 1'd0;
   localparam logic [CsrIdxW-1:0] CsrEdges = 1'd1;

   // bit positions within stitch_edges
   localparam int unsigned EdgeLeft   = 0;
   localparam int unsigned EdgeRight  = 1;
   localparam int unsigned EdgeTop    = 2;
   localparam int unsigned EdgeBottom = 3;

   typedef struct packed {
      logic [SizeW-1:0] quads;   // size already clamped to the maximum
      logic [EdgeW-1:0] edges;
   } cfg_type;

   typedef struct packed {
      logic [SizeW-1:0] x;
      logic [SizeW-1:0] z;
   } coord_type;

   // one classified quad waiting for the back end
   typedef struct packed {
      logic [IndexW-1:0] idx_a;   // (x,z)
      logic [IndexW-1:0] idx_b;   // (x+1,z)
      logic [IndexW-1:0] idx_c;   // (x+1,z+1)
      logic [IndexW-1:0] idx_d;   // (x,z+1)
      logic              tri_lo;  // first triangle survives
      logic              tri_hi;  // second triangle survives
   } entry_type;

endpackage
`default_nettype wire

/* rtl/tpig_front.sv */
// Front end: accepts quads, stitches corners, computes indices, drops empty quads.
// Depends on tpig_pkg; feeds tpig_queue. Quads outside the patch are dropped too.
`default_nettype none
module tpig_front (
   input  wire                          clock,
   input  wire                          reset,
   input  tpig_pkg::cfg_type            cfg,
   input  wire                          in_valid,
   output logic                         in_ready,
   input  wire  [tpig_pkg::CoordW-1:0]  in_x,
   input  wire  [tpig_pkg::CoordW-1:0]  in_z,
   input  wire                          q_full,
   output logic                         q_push,
   output tpig_pkg::entry_type          q_entry
);
   import tpig_pkg::*;

   function automatic coord_type remap(input logic [SizeW-1:0] q,
                                       input logic [EdgeW-1:0] e,
                                       input coord_type c);
      coord_type r;
      r = c;
      if (e[EdgeLeft] && r.x == '0 && r.z[0]) r.z = r.z - 7'd1;
      if (e[EdgeRight] && r.x == q && r.z[0]) r.z = r.z - 7'd1;
      if (e[EdgeTop] && r.z == '0 && r.x[0]) r.x = r.x - 7'd1;
      if (e[EdgeBottom] && r.z == q && r.x[0]) r.x = r.x - 7'd1;
      return r;
   endfunction

   function automatic logic [IndexW-1:0] vindex(input logic [SizeW-1:0] q,
                                                input coord_type c);
      logic [SizeW:0]     row_len;
      logic [2*SizeW:0]   prod;
      row_len = {1'b0, q} + 8'd1;
      prod    = {{(SizeW+1){1'b0}}, c.z} * {{SizeW{1'b0}}, row_len}
              + {{(SizeW+1){1'b0}}, c.x};
      return prod[IndexW-1:0];
   endfunction

   logic       stage_valid_ff, stage_valid_in;
   coord_type  corner_ff [4];
   coord_type  corner_in [4];
   logic       in_range;
   logic       has_result;
   logic       advance;
   logic [SizeW-1:0] x_lo, x_hi, z_lo, z_hi;
   entry_type  entry;

   assign x_lo = {1'b0, in_x};
   assign z_lo = {1'b0, in_z};
   assign x_hi = x_lo + 7'd1;
   assign z_hi = z_lo + 7'd1;
   assign in_range = (x_lo < cfg.quads) && (z_lo < cfg.quads);

   always_comb begin
      corner_in[0] = remap(cfg.quads, cfg.edges, coord_type'{x: x_lo, z: z_lo});
      corner_in[1] = remap(cfg.quads, cfg.edges, coord_type'{x: x_hi, z: z_lo});
      corner_in[2] = remap(cfg.quads, cfg.edges, coord_type'{x: x_hi, z: z_hi});
      corner_in[3] = remap(cfg.quads, cfg.edges, coord_type'{x: x_lo, z: z_hi});
   end

   always_comb begin
      entry.idx_a  = vindex(cfg.quads, corner_ff[0]);
      entry.idx_b  = vindex(cfg.quads, corner_ff[1]);
      entry.idx_c  = vindex(cfg.quads, corner_ff[2]);
      entry.idx_d  = vindex(cfg.quads, corner_ff[3]);
      entry.tri_lo = (entry.idx_a != entry.idx_b) && (entry.idx_b != entry.idx_c)
                  && (entry.idx_a != entry.idx_c);
      entry.tri_hi = (entry.idx_a != entry.idx_c) && (entry.idx_c != entry.idx_d)
                  && (entry.idx_a != entry.idx_d);
   end

   assign has_result = entry.tri_lo || entry.tri_hi;
   // a staged quad without triangles simply drops
   assign advance  = !stage_valid_ff || !has_result || !q_full;
   assign in_ready = advance;
   assign q_push   = stage_valid_ff && has_result && !q_full;
   assign q_entry  = entry;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (advance) begin
         stage_valid_in = in_valid && in_range;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         corner_ff <= corner_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/tpig_queue.sv */
// Two-entry queue between the front and back ends.
// Depends on tpig_pkg for the entry type.
`default_nettype none
module tpig_queue (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  tpig_pkg::entry_type  push_entry,
   input  wire                  pop,
   output tpig_pkg::entry_type  head,
   output logic                 full,
   output logic                 empty
);
   import tpig_pkg::*;

   localparam int unsigned Depth = 2;

   entry_type         slot_ff [Depth];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full  = (count_ff == 2'(Depth));
   assign empty = (count_ff == 2'd0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full)) else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty)) else $error("queue pop while empty");
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(Depth)) else $error("queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> !empty) else $error("queue lost a pushed entry");

endmodule
`default_nettype wire

/* rtl/tpig_back.sv */
// Back end: walks a queued quad and sends one vertex index per transfer.
// Depends on tpig_pkg; reads from tpig_queue.
`default_nettype none
module tpig_back (
   input  wire                          clock,
   input  wire                          reset,
   input  tpig_pkg::entry_type          head,
   input  wire                          q_empty,
   output logic                         q_pop,
   output logic                         out_valid,
   input  wire                          out_ready,
   output logic [tpig_pkg::IndexW-1:0]  out_index,
   output logic                         out_last
);
   import tpig_pkg::*;

   entry_type          cur_ff;
   logic               cur_valid_ff, cur_valid_in;
   logic [2:0]         pos_ff, pos_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [IndexW-1:0]  rsp_index_ff;
   logic               rsp_last_ff;
   logic               slot_free;
   logic               emit;
   logic               is_last;
   logic               take;
   logic [IndexW-1:0]  sel_index;

   assign slot_free = !rsp_valid_ff || out_ready;
   assign emit      = cur_valid_ff && slot_free;
   // final position: end of second triangle if it survives, else end of first
   assign is_last   = (pos_ff == (cur_ff.tri_hi ? 3'd5 : 3'd2));
   assign take      = !q_empty && (!cur_valid_ff || (emit && is_last));
   assign q_pop     = take;

   always_comb begin
      case (pos_ff)
         3'd0, 3'd3: sel_index = cur_ff.idx_a;
         3'd1:       sel_index = cur_ff.idx_b;
         3'd2, 3'd4: sel_index = cur_ff.idx_c;
         default:    sel_index = cur_ff.idx_d;
      endcase
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      pos_in       = pos_ff;
      if (take) begin
         cur_valid_in = 1'b1;
         pos_in       = head.tri_lo ? 3'd0 : 3'd3;
      end else if (emit) begin
         cur_valid_in = !is_last;
         pos_in       = pos_ff + 3'd1;
      end
      rsp_valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         pos_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= head;
      end
      if (emit) begin
         rsp_index_ff <= sel_index;
         rsp_last_ff  <= is_last;
      end
   end

   assign out_valid = rsp_valid_ff;
   assign out_index = rsp_index_ff;
   assign out_last  = rsp_last_ff;

endmodule
`default_nettype wire

/* rtl/terrain_patch_index_generator.sv */
// Throughput: one index per cycle while rsp_tready is held high; a quad sends three or six
// indices, set by how many of its two triangles survive stitching. A quad with no
// triangles is dropped in the front end and sends no index.
// Reset (synchronous): quads_per_side returns to 32, stitch_edges to 0, queue and
// output register empty.
`default_nettype none
module terrain_patch_index_generator #(
   parameter int MAX_PATCH_QUADS = 64
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,    // [5:0] quad_x, [11:6] quad_z, [15:12] zero
   // response channel
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [15:0] rsp_tdata,    // [12:0] vertex_index, [15:13] zero
   output logic        rsp_tlast,
   // configuration writes
   input  wire         csr_we,
   input  wire  [tpig_pkg::CsrIdxW-1:0] csr_index,
   input  wire  [tpig_pkg::SizeW-1:0]   csr_wdata
);
   import tpig_pkg::*;

   logic [SizeW-1:0]   quads_ff, quads_in;
   logic [EdgeW-1:0]   edges_ff, edges_in;
   cfg_type            cfg;
   logic               q_push, q_pop, q_full, q_empty;
   entry_type          push_entry, head;
   logic [IndexW-1:0]  index;

   // Hold the configuration; the user writes only while the block is idle (not enforced).
   always_comb begin
      quads_in = quads_ff;
      edges_in = edges_ff;
      if (csr_we) begin
         unique case (csr_index)
            CsrQuads: quads_in = csr_wdata;
            CsrEdges: edges_in = csr_wdata[EdgeW-1:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quads_ff <= 7'd32;
         edges_ff <= '0;
      end else begin
         quads_ff <= quads_in;
         edges_ff <= edges_in;
      end
   end

   // Clamp the size to the largest supported patch.
   always_comb begin
      cfg.edges = edges_ff;
      if (int'({25'd0, quads_ff}) > MAX_PATCH_QUADS) begin
         cfg.quads = SizeW'(MAX_PATCH_QUADS);
      end else begin
         cfg.quads = quads_ff;
      end
   end

   // Front end: stitch corners, compute indices, drop empty or out-of-range quads.
   tpig_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_x     (req_tdata[5:0]),
      .in_z     (req_tdata[11:6]),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_entry  (push_entry)
   );

   // Decouple classification from emission.
   tpig_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (push_entry),
      .pop        (q_pop),
      .head       (head),
      .full       (q_full),
      .empty      (q_empty)
   );

   // Back end: one index per transfer, tlast on the final one of a quad.
   tpig_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_index (index),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = {3'b000, index};

endmodule
`default_nettype wire
